// ===== hdl/bps_pkg.sv =====
// Shared types, register indexes and helpers for the battery power sequencer.
// No dependencies; used by battery_power_sequencer_unit.
package bps_pkg;

  localparam int unsigned CurWidth    = 16;
  localparam int unsigned CntWidth    = 8;
  localparam int unsigned ReportWidth = 12;
  localparam int unsigned InWidth     = 40;
  localparam int unsigned OutWidth    = 32;
  localparam int unsigned CfgAddrWidth = 3;
  localparam int unsigned CfgDataWidth = 16;

  // Configuration register indexes
  localparam logic [CfgAddrWidth-1:0] REG_CURRENT_LIMIT       = 3'd0;
  localparam logic [CfgAddrWidth-1:0] REG_VOLTAGE_HIGH_LIMIT  = 3'd1;
  localparam logic [CfgAddrWidth-1:0] REG_VOLTAGE_LOW_LIMIT   = 3'd2;
  localparam logic [CfgAddrWidth-1:0] REG_VOLTAGE_COUNT_LIMIT = 3'd3;
  localparam logic [CfgAddrWidth-1:0] REG_CURRENT_COUNT_LIMIT = 3'd4;
  localparam logic [CfgAddrWidth-1:0] REG_BUS_TIMEOUT_LIMIT   = 3'd5;
  localparam logic [CfgAddrWidth-1:0] REG_MOTOR_DELAY_LIMIT   = 3'd6;

  // Register reset values
  localparam logic [CurWidth-1:0] RST_CURRENT_LIMIT       = 16'd1000;
  localparam logic [CurWidth-1:0] RST_VOLTAGE_HIGH_LIMIT  = 16'd4102;
  localparam logic [CurWidth-1:0] RST_VOLTAGE_LOW_LIMIT   = 16'd2051;
  localparam logic [CntWidth-1:0] RST_VOLTAGE_COUNT_LIMIT = 8'd10;
  localparam logic [CntWidth-1:0] RST_CURRENT_COUNT_LIMIT = 8'd2;
  localparam logic [CntWidth-1:0] RST_BUS_TIMEOUT_LIMIT   = 8'd5;
  localparam logic [CntWidth-1:0] RST_MOTOR_DELAY_LIMIT   = 8'd10;

  typedef enum logic [1:0] {
    MODE_WAIT     = 2'd0,
    MODE_ACTIVE   = 2'd1,
    MODE_SHUTDOWN = 2'd2
  } mode_t;

  // Input item, last field in the lowest bits
  typedef struct packed {
    logic [3:0]          pad;
    logic                cmd_motor_on;
    logic                cmd_power_off;
    logic                command_fresh;
    logic                emergency_switch;
    logic [CurWidth-1:0] voltage_sample;
    logic [CurWidth-1:0] current_sample;
  } in_item_t;

  // Result item, last field in the lowest bits
  typedef struct packed {
    logic                   pad;
    logic [ReportWidth-1:0] voltage_report;
    logic [ReportWidth-1:0] current_report;
    logic                   motor_ready;
    logic                   emergency_report;
    logic                   battery_fault;
    logic                   compute_power_on;
    logic                   relay_on;
    mode_t                  mode;
  } out_item_t;

  // Saturating increment of an 8-bit count
  function automatic logic [CntWidth-1:0] sat_inc(input logic [CntWidth-1:0] c);
    logic [CntWidth-1:0] r;
    r = (c == {CntWidth{1'b1}}) ? c : c + 1'b1;
    return r;
  endfunction

endpackage

// ===== hdl/battery_power_sequencer_unit.sv =====
// Battery power sequencer: qualifiers, mode machine and relay/supply drive.
// Depends on bps_pkg for types, register indexes and the saturating count.
//
// Path: an input transfer is held in the input register, then moves to the
// result register once that is free or draining, and waits there for the sink.
// Throughput: one item per cycle while the sink is ready; a stalled sink holds
// both registers. Synchronous active-low reset clears the mode machine,
// counters, latches and loads register defaults.
module battery_power_sequencer_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [15:0] current_sample, [31:16] voltage_sample, [32] emergency_switch,
  // [33] command_fresh, [34] cmd_power_off, [35] cmd_motor_on, [39:36] zero
  input  logic [bps_pkg::InWidth-1:0]       in_tdata,
  // Result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [1:0] mode, [2] relay_on, [3] compute_power_on, [4] battery_fault,
  // [5] emergency_report, [6] motor_ready, [18:7] current_report,
  // [30:19] voltage_report, [31] zero
  output logic [bps_pkg::OutWidth-1:0]      out_tdata,
  // Configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bps_pkg::CfgAddrWidth-1:0]  cfg_addr,
  input  logic [bps_pkg::CfgDataWidth-1:0]  cfg_data
);

  localparam int unsigned CW = bps_pkg::CurWidth;
  localparam int unsigned NW = bps_pkg::CntWidth;

  // Configuration registers
  logic [CW-1:0] cur_limit_r, volt_hi_r, volt_lo_r;
  logic [NW-1:0] volt_cnt_lim_r, cur_cnt_lim_r, bus_to_lim_r, motor_dly_lim_r;

  // Pipeline registers
  logic               in_valid_r;
  bps_pkg::in_item_t  in_r;
  logic               out_valid_r;
  bps_pkg::out_item_t out_r, out_nxt;
  logic               process;

  // Sequencer state
  bps_pkg::mode_t mode_r, mode_nxt;
  logic [NW-1:0]  volt_bad_r, volt_bad_nxt;
  logic [NW-1:0]  cur_bad_r, cur_bad_nxt;
  logic [NW-1:0]  missed_r, missed_nxt;
  logic [NW-1:0]  relay_cnt_r, relay_cnt_nxt;
  logic           fault_hold_r, fault_hold_nxt;
  logic           sd_prev_r, sd_prev_nxt;
  logic           rel_prev_r, rel_prev_nxt;

  logic fault, ready, relay, compute, hold_mid;

  // Config port never stalls; the user must write only while the block is idle (not enforced here).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_limit_r     <= bps_pkg::RST_CURRENT_LIMIT;
      volt_hi_r       <= bps_pkg::RST_VOLTAGE_HIGH_LIMIT;
      volt_lo_r       <= bps_pkg::RST_VOLTAGE_LOW_LIMIT;
      volt_cnt_lim_r  <= bps_pkg::RST_VOLTAGE_COUNT_LIMIT;
      cur_cnt_lim_r   <= bps_pkg::RST_CURRENT_COUNT_LIMIT;
      bus_to_lim_r    <= bps_pkg::RST_BUS_TIMEOUT_LIMIT;
      motor_dly_lim_r <= bps_pkg::RST_MOTOR_DELAY_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        bps_pkg::REG_CURRENT_LIMIT:       cur_limit_r     <= cfg_data;
        bps_pkg::REG_VOLTAGE_HIGH_LIMIT:  volt_hi_r       <= cfg_data;
        bps_pkg::REG_VOLTAGE_LOW_LIMIT:   volt_lo_r       <= cfg_data;
        bps_pkg::REG_VOLTAGE_COUNT_LIMIT: volt_cnt_lim_r  <= cfg_data[NW-1:0];
        bps_pkg::REG_CURRENT_COUNT_LIMIT: cur_cnt_lim_r   <= cfg_data[NW-1:0];
        bps_pkg::REG_BUS_TIMEOUT_LIMIT:   bus_to_lim_r    <= cfg_data[NW-1:0];
        bps_pkg::REG_MOTOR_DELAY_LIMIT:   motor_dly_lim_r <= cfg_data[NW-1:0];
        default: ;
      endcase
    end
  end

  // Advance the held item whenever the result register is free or draining.
  assign process   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || process;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_r <= bps_pkg::in_item_t'(in_tdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (process) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      out_r <= out_nxt;
    end
  end

  // Qualifiers: consecutive bad-tick counts, cleared on a good tick.
  always_comb begin
    volt_bad_nxt = (in_r.voltage_sample > volt_hi_r || in_r.voltage_sample < volt_lo_r)
                   ? bps_pkg::sat_inc(volt_bad_r) : '0;
    cur_bad_nxt  = (in_r.current_sample > cur_limit_r)
                   ? bps_pkg::sat_inc(cur_bad_r) : '0;
    fault = (volt_bad_nxt > volt_cnt_lim_r) || (cur_bad_nxt > cur_cnt_lim_r);
    ready = relay_cnt_r > motor_dly_lim_r;
  end

  // Next state of the mode machine and its counters.
  always_comb begin
    mode_nxt      = mode_r;
    missed_nxt    = missed_r;
    relay_cnt_nxt = relay_cnt_r;
    sd_prev_nxt   = sd_prev_r;
    hold_mid      = fault_hold_r;
    case (mode_r)
      bps_pkg::MODE_SHUTDOWN: begin
        // Leave shutdown on a release of the emergency switch
        mode_nxt    = (sd_prev_r && !in_r.emergency_switch)
                      ? bps_pkg::MODE_WAIT : bps_pkg::MODE_SHUTDOWN;
        sd_prev_nxt = in_r.emergency_switch;
      end
      bps_pkg::MODE_ACTIVE: begin
        hold_mid   = fault_hold_r | fault;
        missed_nxt = in_r.command_fresh ? '0 : bps_pkg::sat_inc(missed_r);
        if (in_r.cmd_power_off && !in_r.cmd_motor_on) begin
          mode_nxt = bps_pkg::MODE_SHUTDOWN;
        end else if (missed_nxt > bus_to_lim_r) begin
          mode_nxt = bps_pkg::MODE_WAIT;
        end else begin
          mode_nxt = bps_pkg::MODE_ACTIVE;
        end
        relay_cnt_nxt = relay ? bps_pkg::sat_inc(relay_cnt_r) : '0;
      end
      default: begin
        // Wait, and the unused code, which behaves as wait
        if (in_r.command_fresh) begin
          missed_nxt = '0;
          mode_nxt   = bps_pkg::MODE_ACTIVE;
        end else begin
          mode_nxt   = bps_pkg::MODE_WAIT;
        end
      end
    endcase
    // Fault hold release on a falling switch edge, tracked only while held
    fault_hold_nxt = hold_mid;
    rel_prev_nxt   = rel_prev_r;
    if (hold_mid) begin
      rel_prev_nxt = in_r.emergency_switch;
      if (rel_prev_r && !in_r.emergency_switch) begin
        fault_hold_nxt = 1'b0;
      end
    end
  end

  // Relay and compute drive per mode.
  always_comb begin
    relay   = 1'b0;
    compute = 1'b1;
    case (mode_r)
      bps_pkg::MODE_SHUTDOWN: begin
        compute = 1'b0;
      end
      bps_pkg::MODE_ACTIVE: begin
        relay = !fault && !in_r.emergency_switch && in_r.cmd_motor_on && !fault_hold_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_nxt                  = '0;
    out_nxt.mode             = mode_nxt;
    out_nxt.relay_on         = relay;
    out_nxt.compute_power_on = compute;
    out_nxt.battery_fault    = fault;
    out_nxt.emergency_report = in_r.emergency_switch;
    out_nxt.motor_ready      = ready;
    out_nxt.current_report   = in_r.current_sample[CW-1:4];
    out_nxt.voltage_report   = in_r.voltage_sample[CW-1:4];
  end

  // Commit state once per processed tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= bps_pkg::MODE_WAIT;
      volt_bad_r   <= '0;
      cur_bad_r    <= '0;
      missed_r     <= '0;
      relay_cnt_r  <= '0;
      fault_hold_r <= 1'b0;
      sd_prev_r    <= 1'b0;
      rel_prev_r   <= 1'b0;
    end else if (process) begin
      mode_r       <= mode_nxt;
      volt_bad_r   <= volt_bad_nxt;
      cur_bad_r    <= cur_bad_nxt;
      missed_r     <= missed_nxt;
      relay_cnt_r  <= relay_cnt_nxt;
      fault_hold_r <= fault_hold_nxt;
      sd_prev_r    <= sd_prev_nxt;
      rel_prev_r   <= rel_prev_nxt;
    end
  end

`ifndef SYNTHESIS
  // Shutdown ticks always drop both the relay and the compute supply.
  a_shutdown_off: assert property (@(posedge clk) disable iff (!rst_n)
    process && mode_r == bps_pkg::MODE_SHUTDOWN
    |=> !out_r.relay_on && !out_r.compute_power_on)
    else $error("relay or compute on during shutdown");

  // A held battery fault keeps the relay open.
  a_hold_blocks_relay: assert property (@(posedge clk) disable iff (!rst_n)
    process && fault_hold_r |=> !out_r.relay_on)
    else $error("relay closed while fault is held");

  // With both stages full and the sink stalled, no new transfer is taken.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_valid_r && !out_tready |-> !in_tready)
    else $error("input taken while pipeline is full and stalled");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for battery_power_sequencer_unit: streams control ticks,
// predicts every status result in step with the stimulus and checks each one.
// Depends on bps_pkg (types, register indexes, reset values) and the RTL only.
module tb;
  import bps_pkg::*;

  localparam int unsigned WatchdogLimit = 3000;  // cycles with no transfer at all
  localparam int unsigned LongHold      = 400;   // receiver back-pressure stretch

  // Limit registers as the bench sees them
  typedef struct packed {
    logic [CurWidth-1:0] current_max;
    logic [CurWidth-1:0] volt_high;
    logic [CurWidth-1:0] volt_low;
    logic [CntWidth-1:0] volt_runs;
    logic [CntWidth-1:0] curr_runs;
    logic [CntWidth-1:0] bus_misses;
    logic [CntWidth-1:0] motor_delay;
  } limits_t;

  localparam limits_t DefaultLimits = '{
    current_max: RST_CURRENT_LIMIT, volt_high: RST_VOLTAGE_HIGH_LIMIT,
    volt_low: RST_VOLTAGE_LOW_LIMIT, volt_runs: RST_VOLTAGE_COUNT_LIMIT,
    curr_runs: RST_CURRENT_COUNT_LIMIT, bus_misses: RST_BUS_TIMEOUT_LIMIT,
    motor_delay: RST_MOTOR_DELAY_LIMIT};

  logic                    clk;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic [InWidth-1:0]      in_tdata   = '0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OutWidth-1:0]     out_tdata;
  logic                    cfg_valid  = 1'b0;
  logic                    cfg_ready;
  logic [CfgAddrWidth-1:0] cfg_addr   = '0;
  logic [CfgDataWidth-1:0] cfg_data   = '0;

  battery_power_sequencer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stimulus waiting for the driver, and status results waiting for the DUT
  in_item_t    ticks_to_send[$];
  out_item_t   predicted_status[$];

  // Limits the stimulus generator aims at (set when a phase loads them)
  limits_t     plan = DefaultLimits;

  // Predictor copy of the limit registers and of the sequencer state
  limits_t             live_limits = DefaultLimits;
  mode_t               op_mode     = MODE_WAIT;
  logic [CntWidth-1:0] volt_run    = '0;
  logic [CntWidth-1:0] curr_run    = '0;
  logic [CntWidth-1:0] miss_run    = '0;
  logic [CntWidth-1:0] relay_run   = '0;
  logic                hold_latch  = 1'b0;
  logic                sd_prev_sw  = 1'b0;
  logic                rel_prev_sw = 1'b0;

  // Bookkeeping
  int unsigned cycle_no        = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned send_gap        = 0;
  int unsigned recv_gap        = 0;
  int unsigned hold_left       = 0;
  int unsigned ticks_planned   = 0;
  int unsigned settings_loaded = 0;
  int unsigned results_seen    = 0;
  int unsigned mismatches      = 0;
  int unsigned input_stalls    = 0;
  int unsigned long_holds      = 0;
  int unsigned seen_fault      = 0;
  int unsigned seen_relay      = 0;
  int unsigned seen_ready      = 0;
  int unsigned seen_shutdown   = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [CntWidth-1:0] count_up(input logic [CntWidth-1:0] c);
    // counts stick at all ones instead of wrapping
    return (&c) ? c : c + 1'b1;
  endfunction

  // Advance the sequencer by one control tick and return its status report
  function automatic out_item_t advance_tick(input in_item_t t);
    out_item_t r;
    logic      fault;
    logic      sw;
    logic      falling;
    r  = '0;
    sw = t.emergency_switch;

    // Qualifiers: consecutive bad samples, cleared by one good sample
    if (t.voltage_sample > live_limits.volt_high || t.voltage_sample < live_limits.volt_low)
      volt_run = count_up(volt_run);
    else
      volt_run = '0;
    if (t.current_sample > live_limits.current_max)
      curr_run = count_up(curr_run);
    else
      curr_run = '0;
    fault = (volt_run > live_limits.volt_runs) || (curr_run > live_limits.curr_runs);

    // Motor ready looks at the relay count as it stood before this tick
    r.motor_ready      = relay_run > live_limits.motor_delay;
    r.compute_power_on = 1'b1;

    case (op_mode)
      MODE_SHUTDOWN: begin
        r.compute_power_on = 1'b0;
        if (sd_prev_sw && !sw) op_mode = MODE_WAIT;
        sd_prev_sw = sw;
      end
      MODE_ACTIVE: begin
        if (fault) hold_latch = 1'b1;
        miss_run = t.command_fresh ? '0 : count_up(miss_run);
        // command bits count here even when no new command came in
        if (t.cmd_power_off && !t.cmd_motor_on)
          op_mode = MODE_SHUTDOWN;
        else if (miss_run > live_limits.bus_misses)
          op_mode = MODE_WAIT;
        if (!fault && !sw && t.cmd_motor_on && !hold_latch) begin
          r.relay_on = 1'b1;
          relay_run  = count_up(relay_run);
        end else begin
          relay_run = '0;
        end
      end
      default: begin
        op_mode = MODE_WAIT;
        if (t.command_fresh) begin
          miss_run = '0;
          op_mode  = MODE_ACTIVE;
        end
      end
    endcase

    // Fault latch: a switch release clears it; the edge detector only runs while set
    if (hold_latch) begin
      falling     = rel_prev_sw && !sw;
      rel_prev_sw = sw;
      if (falling) hold_latch = 1'b0;
    end

    r.mode             = op_mode;
    r.battery_fault    = fault;
    r.emergency_report = sw;
    r.current_report   = t.current_sample[CurWidth-1:4];
    r.voltage_report   = t.voltage_sample[CurWidth-1:4];
    return r;
  endfunction

  // Track limit writes and predict every accepted tick, in transfer order
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          REG_CURRENT_LIMIT:       live_limits.current_max = cfg_data;
          REG_VOLTAGE_HIGH_LIMIT:  live_limits.volt_high   = cfg_data;
          REG_VOLTAGE_LOW_LIMIT:   live_limits.volt_low    = cfg_data;
          REG_VOLTAGE_COUNT_LIMIT: live_limits.volt_runs   = cfg_data[CntWidth-1:0];
          REG_CURRENT_COUNT_LIMIT: live_limits.curr_runs   = cfg_data[CntWidth-1:0];
          REG_BUS_TIMEOUT_LIMIT:   live_limits.bus_misses  = cfg_data[CntWidth-1:0];
          REG_MOTOR_DELAY_LIMIT:   live_limits.motor_delay = cfg_data[CntWidth-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predicted_status.push_back(advance_tick(in_tdata));
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: offer queued ticks, with random gaps between transfers
  // ---------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(25, 80);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      // Slot is free: the last tick (if any) was just transferred
      if (send_gap != 0) begin
        send_gap  <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (ticks_to_send.size() != 0) begin
        in_tdata  <= ticks_to_send.pop_front();
        in_tvalid <= 1'b1;
        // one stretch in three runs back to back with no gaps
        if (((cycle_no >> 7) % 3) != 0 && $urandom_range(0, 3) == 0)
          send_gap <= pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end else begin
      input_stalls++;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check results against predictions, drive back-pressure
  // ---------------------------------------------------------------------------

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    results_seen++;
    if (predicted_status.size() == 0) begin
      mismatches++;
      $display("%0t: status result with nothing expected, got %h", $time, got);
      return;
    end
    want = predicted_status.pop_front();
    check_field("mode",             want.mode,             got.mode);
    check_field("relay_on",         want.relay_on,         got.relay_on);
    check_field("compute_power_on", want.compute_power_on, got.compute_power_on);
    check_field("battery_fault",    want.battery_fault,    got.battery_fault);
    check_field("emergency_report", want.emergency_report, got.emergency_report);
    check_field("motor_ready",      want.motor_ready,      got.motor_ready);
    check_field("current_report",   want.current_report,   got.current_report);
    check_field("voltage_report",   want.voltage_report,   got.voltage_report);
    check_field("pad",              0,                     got.pad);
    seen_fault    += got.battery_fault;
    seen_relay    += got.relay_on;
    seen_ready    += got.motor_ready;
    seen_shutdown += (got.mode == MODE_SHUTDOWN);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_result(out_tdata);
      if (hold_left != 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (out_tvalid && out_tready && (results_seen == 150 || results_seen == 700)) begin
        // Hold off long enough for the DUT to fill and stall its input
        hold_left  <= LongHold - 1;
        out_tready <= 1'b0;
        long_holds <= long_holds + 1;
      end else if (recv_gap != 0) begin
        recv_gap   <= recv_gap - 1;
        out_tready <= 1'b0;
      end else if ((((cycle_no >> 7) + 1) % 3) != 0 && $urandom_range(0, 4) == 0) begin
        recv_gap   <= pick_gap() - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if no channel moves for too long
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
               WatchdogLimit, predicted_status.size());
      $display("battery_power_sequencer_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  task automatic push_tick(input logic [CurWidth-1:0] cur, input logic [CurWidth-1:0] volt,
                           input logic sw, fresh, off, motor);
    in_item_t t;
    t                  = '0;
    t.current_sample   = cur;
    t.voltage_sample   = volt;
    t.emergency_switch = sw;
    t.command_fresh    = fresh;
    t.cmd_power_off    = off;
    t.cmd_motor_on     = motor;
    ticks_to_send.push_back(t);
    ticks_planned++;
  endtask

  // Current sample above or within the planned limit, limit edges favored
  function automatic logic [CurWidth-1:0] pick_current(input logic over);
    if (over) begin
      if (plan.current_max == 16'hFFFF) return 16'hFFFF;  // nothing lies above
      if ($urandom_range(0, 3) == 0) return plan.current_max + 16'd1;
      return 16'($urandom_range(32'(plan.current_max) + 1, 65535));
    end
    if ($urandom_range(0, 3) == 0) return plan.current_max;
    return 16'($urandom_range(0, 32'(plan.current_max)));
  endfunction

  // Voltage sample outside or inside the planned window, edges favored
  function automatic logic [CurWidth-1:0] pick_voltage(input logic outside);
    logic lo_ok;
    logic hi_ok;
    lo_ok = plan.volt_low != 16'd0;
    hi_ok = plan.volt_high != 16'hFFFF;
    if (outside && (lo_ok || hi_ok)) begin
      if (lo_ok && (!hi_ok || $urandom_range(0, 1) == 0))
        return ($urandom_range(0, 3) == 0) ? plan.volt_low - 16'd1 :
               16'($urandom_range(0, 32'(plan.volt_low) - 1));
      return ($urandom_range(0, 3) == 0) ? plan.volt_high + 16'd1 :
             16'($urandom_range(32'(plan.volt_high) + 1, 65535));
    end
    if (plan.volt_low > plan.volt_high) return 16'($urandom);  // empty window
    case ($urandom_range(0, 3))
      0:       return plan.volt_low;
      1:       return plan.volt_high;
      default: return 16'($urandom_range(32'(plan.volt_low), 32'(plan.volt_high)));
    endcase
  endfunction

  // One short, mostly well-formed command sequence with random content
  task automatic add_scenario();
    int unsigned kind;
    logic        on_volt;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      // normal running: fresh commands asking for motor power, rare upsets
      repeat ($urandom_range(4, 30))
        push_tick(pick_current($urandom_range(0, 9) == 0),
                  pick_voltage($urandom_range(0, 9) == 0),
                  $urandom_range(0, 19) == 0, $urandom_range(0, 9) != 0,
                  $urandom_range(0, 7) == 0, $urandom_range(0, 7) != 0);
    end else if (kind < 45) begin
      // fault burst on one qualifier
      on_volt = 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 20))
        push_tick(pick_current(!on_volt), pick_voltage(on_volt), 1'b0, 1'b1, 1'b0, 1'b1);
    end else if (kind < 60) begin
      // press and release the switch, then ask for the motor again
      repeat ($urandom_range(1, 3))
        push_tick(pick_current(1'b0), pick_voltage(1'b0), 1'b1,
                  1'($urandom_range(0, 1)), 1'b0, 1'b1);
      repeat ($urandom_range(1, 2))
        push_tick(pick_current(1'b0), pick_voltage(1'b0), 1'b0,
                  1'($urandom_range(0, 1)), 1'b0, 1'b1);
      push_tick(pick_current(1'b0), pick_voltage(1'b0), 1'b0, 1'b1, 1'b0, 1'b1);
    end else if (kind < 70) begin
      // power-off command with motor off, then a few loose ticks
      push_tick(pick_current(1'b0), pick_voltage(1'b0), 1'b0, 1'b1, 1'b1, 1'b0);
      repeat ($urandom_range(0, 4))
        push_tick(pick_current(1'b0), pick_voltage(1'b0), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'b0, 1'b1);
    end else if (kind < 80) begin
      // bus silence
      repeat ($urandom_range(1, 20))
        push_tick(pick_current(1'b0), pick_voltage(1'b0), 1'b0, 1'b0,
                  1'($urandom_range(0, 1)), 1'b1);
    end else begin
      // noise: every field fully random
      repeat ($urandom_range(1, 5))
        push_tick(16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom),
                  1'($urandom), 1'($urandom));
    end
  endtask

  task automatic add_random_ticks(input int unsigned n);
    int unsigned goal;
    goal = ticks_planned + n;
    while (ticks_planned < goal) add_scenario();
  endtask

  // Let every queued tick go through and every result come back
  task automatic wait_drained();
    do @(posedge clk);
    while (ticks_to_send.size() != 0 || in_tvalid || predicted_status.size() != 0);
    repeat (4) @(posedge clk);  // two-stage pipeline, give it room to settle
  endtask

  // Write all seven limit registers back to back, one transfer each
  task automatic load_limits(input limits_t l);
    logic [CfgAddrWidth-1:0] idx[7];
    logic [CfgDataWidth-1:0] val[7];
    idx = '{REG_CURRENT_LIMIT, REG_VOLTAGE_HIGH_LIMIT, REG_VOLTAGE_LOW_LIMIT,
            REG_VOLTAGE_COUNT_LIMIT, REG_CURRENT_COUNT_LIMIT, REG_BUS_TIMEOUT_LIMIT,
            REG_MOTOR_DELAY_LIMIT};
    val = '{l.current_max, l.volt_high, l.volt_low, 16'(l.volt_runs), 16'(l.curr_runs),
            16'(l.bus_misses), 16'(l.motor_delay)};
    plan = l;
    settings_loaded++;
    for (int k = 0; k < 7; k++) begin
      cfg_addr  <= idx[k];
      cfg_data  <= val[k];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    limits_t             rand_lim;
    logic [CurWidth-1:0] va;
    logic [CurWidth-1:0] vb;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // ---- Directed part, reset limits -------------------------------------
    // wait mode, no command; voltage below the window, zero current
    push_tick(16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    // command arrives: enter active; its power-off bit is ignored in wait
    push_tick(16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b1);
    // relay run at the limit current and both window edges; one missed
    // command and one stale power-off bit with motor on (no shutdown);
    // the twelfth tick reports motor ready
    for (int i = 0; i < 12; i++)
      push_tick(16'd1000, (i % 2 == 1) ? 16'd4102 : 16'd2051, 1'b0, i != 5, i == 7, 1'b1);
    // overcurrent three ticks running: fault on the third, latch set
    repeat (3) push_tick(16'd1001, 16'd3000, 1'b0, 1'b1, 1'b0, 1'b1);
    // press then release the switch: the release clears the latch
    push_tick(16'd0, 16'd3000, 1'b1, 1'b1, 1'b0, 1'b1);
    push_tick(16'd0, 16'd3000, 1'b0, 1'b1, 1'b0, 1'b1);
    // power off with motor off: shutdown, compute supply drops
    push_tick(16'd500, 16'd3000, 1'b0, 1'b1, 1'b1, 1'b0);
    // in shutdown a switch press and release returns to wait
    push_tick(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b1);
    push_tick(16'd0, 16'd3000, 1'b0, 1'b0, 1'b0, 1'b0);
    // new command, then silence until the bus timeout drops back to wait
    push_tick(16'd0, 16'd3000, 1'b0, 1'b1, 1'b0, 1'b1);
    repeat (6) push_tick(16'd0, 16'd3000, 1'b0, 1'b0, 1'b0, 1'b1);
    wait_drained();

    // ---- Random phases, one limit setting each ---------------------------
    // tighter limits so every path turns up often
    load_limits('{current_max: 16'd2000, volt_high: 16'd3000, volt_low: 16'd1000,
                  volt_runs: 8'd3, curr_runs: 8'd1, bus_misses: 8'd3, motor_delay: 8'd5});
    add_random_ticks(280);
    wait_drained();

    // all zero: any nonzero sample is bad and faults on its first tick
    load_limits('{current_max: 16'd0, volt_high: 16'd0, volt_low: 16'd0,
                  volt_runs: 8'd0, curr_runs: 8'd0, bus_misses: 8'd0, motor_delay: 8'd0});
    add_random_ticks(180);
    wait_drained();

    // all at maximum: no sample is ever bad, no count ever exceeds its limit
    load_limits('{current_max: 16'hFFFF, volt_high: 16'hFFFF, volt_low: 16'd0,
                  volt_runs: 8'hFF, curr_runs: 8'hFF, bus_misses: 8'hFF, motor_delay: 8'hFF});
    add_random_ticks(120);
    wait_drained();

    // counts one short of saturation: long runs show a wrap as a dropped flag
    load_limits('{current_max: 16'd1000, volt_high: 16'd4102, volt_low: 16'd2051,
                  volt_runs: 8'd254, curr_runs: 8'd254, bus_misses: 8'hFF,
                  motor_delay: 8'd254});
    // release any latch and leave shutdown before the runs
    push_tick(16'd0, 16'd3000, 1'b1, 1'b1, 1'b0, 1'b1);
    push_tick(16'd0, 16'd3000, 1'b0, 1'b1, 1'b0, 1'b1);
    push_tick(16'd0, 16'd3000, 1'b0, 1'b1, 1'b0, 1'b1);
    repeat (270) push_tick(16'd200, 16'd3000, 1'b0, 1'b1, 1'b0, 1'b1);
    repeat (270) push_tick(16'd200, 16'd60000, 1'b0, 1'b1, 1'b0, 1'b1);
    add_random_ticks(60);
    wait_drained();

    // random limits, window kept ordered
    va = 16'($urandom);
    vb = 16'($urandom);
    rand_lim.current_max = 16'($urandom);
    rand_lim.volt_low    = (va < vb) ? va : vb;
    rand_lim.volt_high   = (va < vb) ? vb : va;
    rand_lim.volt_runs   = 8'($urandom_range(0, 12));
    rand_lim.curr_runs   = 8'($urandom_range(0, 12));
    rand_lim.bus_misses  = 8'($urandom_range(0, 12));
    rand_lim.motor_delay = 8'($urandom_range(0, 20));
    load_limits(rand_lim);
    add_random_ticks(150);
    wait_drained();

    $display("Ran %0d ticks over reset limits and %0d limit settings, %0d results checked.",
             ticks_planned, settings_loaded, results_seen);
    $display("Saw %0d faults, %0d relay-on, %0d motor-ready, %0d shutdown; input stalled %0d cycles, %0d long holds.",
             seen_fault, seen_relay, seen_ready, seen_shutdown, input_stalls, long_holds);
    if (mismatches == 0) begin
      $display("battery_power_sequencer_unit test passed");
    end else begin
      $display("battery_power_sequencer_unit test failed");
    end
    $finish;
  end

endmodule
